// ===== design/svm_pkg.sv =====
// Package for the sample voice mixer: operation codes, sequencer states and
// shared fixed-point constants. No dependencies.
package svm_pkg;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_WRITE  = 3'd1,
        OP_START  = 3'd2,
        OP_STOP   = 3'd3,
        OP_VOLUME = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MIX,
        ST_NEXT,
        ST_DONE
    } t_state;

    localparam logic signed [47:0] ACC_LIMIT = 48'sd32767 * 48'sd65536;
    localparam logic [15:0] UNITY_VOLUME = 16'd32768;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic [3:0]         started;
        logic               ok;
        logic [15:0]        vread;
    } t_result;

endpackage

// ===== design/svm_mac.sv =====
// Shared multiply unit of the sample voice mixer: interpolation, volume and
// gain scaling of one channel value over several cycles. Uses svm_pkg.
module svm_mac #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_start,
    input  logic signed [15:0]       i_s0,
    input  logic signed [15:0]       i_s1,
    input  logic [FRACTION_BITS-1:0] i_frac,
    input  logic [15:0]              i_volume,
    input  logic [15:0]              i_gain,
    output logic signed [47:0]       o_value
);
    import svm_pkg::*;

    localparam int VW = 16 + FRACTION_BITS + 2;

    logic signed [VW-1:0] r_interp;
    logic signed [47:0]   r_q;
    logic signed [47:0]   r_scaled;
    logic signed [VW-1:0] n_interp;
    logic signed [47:0]   n_q;
    logic signed [VW:0]   w_one;

    always_comb begin
        w_one = (VW+1)'(1) <<< FRACTION_BITS;
        n_interp = VW'(i_s0 * (w_one - $signed({1'b0, i_frac}))
                   + i_s1 * $signed({1'b0, i_frac}));
        if (FRACTION_BITS >= 16) begin
            n_q = 48'(r_interp >>> (FRACTION_BITS - 16));
        end else begin
            n_q = 48'(r_interp) <<< (16 - FRACTION_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_interp <= n_interp;
        end
        r_q      <= (n_q * $signed({1'b0, i_volume})) >>> 15;
        r_scaled <= 48'((52'(r_q) * $signed({1'b0, i_gain})) >>> 15);
    end

    assign o_value = r_scaled;
endmodule

// ===== design/sample_voice_mixer.sv =====
// Top level of the sample voice mixer: voice table, sample memory, sequencer
// and output register. Uses svm_pkg and svm_mac.
//
//  Port group   Dir  Contents
//  s_axis       in   operation and voice fields of one command word
//  m_axis       out  mixed stereo sample, start status and volume readback
//
// A tick walks every voice through the single shared multiply unit: each active
// voice takes two memory reads and a left and a right product, and each free
// voice is skipped. Other operations go from ST_READ straight to ST_DONE.
// Reset clears all voices; the sample memory is not cleared.
// The output holds its word until taken; each stalled cycle delays the next word.
module sample_voice_mixer #(
    parameter int VOICES        = 16,
    parameter int SAMPLE_DEPTH  = 4096,
    parameter int FRACTION_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // operation[2:0], address[14:3], left_sample[30:15], right_sample[46:31],
    // length[59:47], loop_enable[60], step[84:61], sound_gain[100:85],
    // unique_req[101], voice[105:102], volume[121:106], zero[127:122]
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // left_out[15:0], right_out[31:16], started_voice[35:32], start_ok[36],
    // volume_read[52:37], zero[55:53]
    output logic [55:0]  m_axis_tdata
);
    import svm_pkg::*;

    localparam int VI = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int AW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
    localparam int PW = 13 + FRACTION_BITS;

    logic [127:0] r_cmd;
    t_state r_state, n_state;
    logic [VI:0] r_idx;
    logic [3:0]  r_phase;

    logic [VOICES-1:0] r_active;
    logic [11:0]       r_base [VOICES];
    logic [12:0]       r_len  [VOICES];
    logic [VOICES-1:0] r_loop;
    logic [23:0]       r_step [VOICES];
    logic [PW:0]       r_pos  [VOICES];
    logic [15:0]       r_vol  [VOICES];
    logic [15:0]       r_gain [VOICES];

    logic [31:0] r_mem [SAMPLE_DEPTH];
    logic [31:0] r_rd;
    logic [31:0] r_w0, r_w1;
    logic [AW-1:0] w_raddr;

    logic signed [47:0] r_lacc, r_racc;
    t_result r_res;
    logic r_out_valid;

    t_op      w_op;
    logic [11:0] w_addr;
    logic [3:0]  w_vsel;
    logic [VI-1:0] w_v;
    logic signed [47:0] w_mac;
    logic signed [47:0] w_sum;
    logic signed [47:0] w_clamped;
    logic        w_mac_start;
    logic signed [15:0] w_s0, w_s1;
    logic [PW:0] w_newpos;
    logic        w_wrap;
    logic        w_start_ok;
    logic        w_found, w_free;
    logic [VI-1:0] w_found_i, w_free_i;

    assign w_op   = t_op'(r_cmd[2:0]);
    assign w_addr = r_cmd[14:3];
    assign w_vsel = r_cmd[105:102];
    assign w_v    = r_idx[VI-1:0];

    always_comb begin
        w_found = 1'b0; w_found_i = '0; w_free = 1'b0; w_free_i = '0;
        for (int i = VOICES - 1; i >= 0; i--) begin
            if (r_active[i] && r_base[i] == w_addr) begin
                w_found = 1'b1; w_found_i = VI'(i);
            end
            if (!r_active[i]) begin
                w_free = 1'b1; w_free_i = VI'(i);
            end
        end
    end

    assign w_start_ok = (w_op == OP_START) && (!w_found || !r_cmd[101]) && w_free;

    always_comb begin
        if (r_phase[0]) begin
            w_raddr = AW'(32'(r_base[w_v]) + 32'(r_pos[w_v] >> FRACTION_BITS) + 32'd1);
        end else begin
            w_raddr = AW'(32'(r_base[w_v]) + 32'(r_pos[w_v] >> FRACTION_BITS));
        end
    end

    // Per active voice, phases 0 and 1 read both frames, phase 3 starts the
    // left channel, phase 6 adds left and starts right, and phase 9 adds right.
    assign w_mac_start = (r_phase == 4'd3) || (r_phase == 4'd6);
    assign w_s0 = (r_phase == 4'd3) ? r_w0[15:0] : r_w0[31:16];
    assign w_s1 = (r_phase == 4'd3) ? r_w1[15:0] : r_w1[31:16];

    svm_mac #(.FRACTION_BITS(FRACTION_BITS)) u_mac (
        .i_clk    (i_clk),
        .i_start  (w_mac_start),
        .i_s0     (w_s0),
        .i_s1     (w_s1),
        .i_frac   (r_pos[w_v][FRACTION_BITS-1:0]),
        .i_volume (r_vol[w_v]),
        .i_gain   (r_gain[w_v]),
        .o_value  (w_mac)
    );

    always_comb begin
        w_sum = ((r_phase == 4'd6) ? r_lacc : r_racc) + w_mac;
        if (w_sum > ACC_LIMIT) begin
            w_clamped = ACC_LIMIT;
        end else if (w_sum < -ACC_LIMIT) begin
            w_clamped = -ACC_LIMIT;
        end else begin
            w_clamped = w_sum;
        end
        w_newpos = r_pos[w_v] + (PW+1)'(r_step[w_v]);
        w_wrap = (w_newpos + (PW+1)'(1 << FRACTION_BITS))
                 >= ((PW+1)'(r_len[w_v]) << FRACTION_BITS);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (s_axis_tvalid && s_axis_tready) n_state = ST_READ;
            ST_READ: n_state = (w_op == OP_TICK) ? ST_MIX : ST_DONE;
            ST_MIX: begin
                if (r_idx == (VI+1)'(VOICES)) n_state = ST_DONE;
            end
            ST_NEXT: n_state = ST_MIX;
            ST_DONE: if (!r_out_valid) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    assign s_axis_tready = (r_state == ST_IDLE) && !r_out_valid;

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) r_cmd <= s_axis_tdata;
        r_rd <= r_mem[w_raddr];
        if (r_state == ST_READ && w_op == OP_WRITE) begin
            r_mem[AW'(w_addr)] <= {r_cmd[46:31], r_cmd[30:15]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx <= '0;
            r_phase <= '0;
            r_active <= '0;
            r_loop <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < VOICES; i++) begin
                r_base[i] <= '0; r_len[i] <= '0; r_step[i] <= '0;
                r_pos[i] <= '0; r_vol[i] <= '0; r_gain[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (m_axis_tvalid && m_axis_tready) r_out_valid <= 1'b0;
            if (r_state == ST_READ) begin
                r_idx <= '0; r_phase <= '0;
                r_lacc <= '0; r_racc <= '0;
                if (w_start_ok) begin
                    r_active[w_free_i] <= 1'b1;
                    r_base[w_free_i] <= w_addr;
                    r_len[w_free_i] <= r_cmd[59:47];
                    r_loop[w_free_i] <= r_cmd[60];
                    r_step[w_free_i] <= r_cmd[84:61];
                    r_gain[w_free_i] <= r_cmd[100:85];
                    r_pos[w_free_i] <= '0;
                    r_vol[w_free_i] <= UNITY_VOLUME;
                end
                if (w_op == OP_STOP && w_found) begin
                    r_active[w_found_i] <= 1'b0;
                    r_pos[w_found_i] <= '0;
                end
                if (w_op == OP_VOLUME && 32'(w_vsel) < VOICES) begin
                    r_vol[VI'(w_vsel)] <= r_cmd[121:106];
                end
            end
            if (r_state == ST_MIX && r_idx != (VI+1)'(VOICES)) begin
                if (!r_active[w_v]) begin
                    r_idx <= r_idx + 1'b1;
                end else begin
                    r_phase <= (r_phase == 4'd9) ? 4'd0 : r_phase + 1'b1;
                    if (r_phase == 4'd1) r_w0 <= r_rd;
                    if (r_phase == 4'd2) r_w1 <= r_rd;
                    if (r_phase == 4'd6) r_lacc <= w_clamped;
                    if (r_phase == 4'd9) begin
                        r_racc <= w_clamped;
                        r_idx <= r_idx + 1'b1;
                        r_pos[w_v] <= (w_wrap && r_loop[w_v]) ? '0 : w_newpos;
                        if (w_wrap && !r_loop[w_v]) r_active[w_v] <= 1'b0;
                    end
                end
            end
            if (n_state == ST_DONE && r_state != ST_DONE) begin
                r_out_valid <= 1'b1;
                r_res.left  <= (r_state == ST_READ) ? 16'sd0
                               : 16'((r_lacc + 48'sd32768) >>> 16);
                r_res.right <= (r_state == ST_READ) ? 16'sd0
                               : 16'((r_racc + 48'sd32768) >>> 16);
                r_res.started <= (r_state == ST_READ && w_start_ok) ? 4'(w_free_i) : 4'd0;
                r_res.ok <= (r_state == ST_READ) && w_start_ok;
                r_res.vread <= (32'(w_vsel) < VOICES)
                    ? ((w_op == OP_VOLUME) ? r_cmd[121:106]
                       : (r_state == ST_READ && w_start_ok && w_free_i == VI'(w_vsel))
                         ? UNITY_VOLUME : r_vol[VI'(w_vsel)])
                    : 16'd0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = {3'd0, r_res.vread, r_res.ok, r_res.started,
                           r_res.right, r_res.left};

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> !s_axis_tready) else $error("ready while busy");
    a_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= 4'd9) else $error("phase overrun");
    a_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_MIX |-> (r_lacc <= ACC_LIMIT && r_lacc >= -ACC_LIMIT))
        else $error("accumulator out of range");
endmodule

// ===== tb/svm_checker.sv =====
// Checker for the sample voice mixer: watches both stream channels, predicts
// every output word from its own voice table and compares field by field.
// Depends on svm_pkg for the operation codes.
module svm_checker
    import svm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [55:0]  m_axis_tdata,
    output int           o_errors,
    output int           o_pending,
    output int           o_ticks,
    output int           o_starts
);

    localparam int NV = 16;
    localparam longint LIMIT = 64'sd32767 * 64'sd65536;

    logic [31:0] mem [0:4095];
    logic        act [NV];
    logic [11:0] base [NV];
    logic [12:0] len [NV];
    logic        loops [NV];
    logic [23:0] stp [NV];
    logic [27:0] pos [NV];
    logic [15:0] vol [NV];
    logic [15:0] gain [NV];

    logic [55:0] mix_words [$];

    function automatic longint flr(longint x, int n);
        return x >>> n;
    endfunction

    function automatic longint half(int a, bit r);
        logic [31:0] w;
        w = mem[a % 4096];
        return r ? longint'($signed(w[31:16])) : longint'($signed(w[15:0]));
    endfunction

    function automatic longint contrib(int v, bit r);
        longint s0, s1, f, q;
        int ip;
        ip = int'(pos[v] >> 16);
        f = longint'(pos[v][15:0]);
        s0 = half(int'(base[v]) + ip, r);
        s1 = half(int'(base[v]) + ip + 1, r);
        q = s0 * (65536 - f) + s1 * f;
        q = flr(q * longint'(vol[v]), 15);
        return flr(q * longint'(gain[v]), 15);
    endfunction

    function automatic longint clampacc(longint a);
        if (a > LIMIT) return LIMIT;
        if (a < -LIMIT) return -LIMIT;
        return a;
    endfunction

    task automatic predict_mix(input logic [127:0] d);
        t_op op;
        logic [11:0] addr;
        logic [3:0] vs;
        longint la, ra;
        logic [15:0] lo, ro;
        logic [3:0] sv;
        logic ok, found;
        longint np;
        op = t_op'(d[2:0]);
        addr = d[14:3];
        vs = d[105:102];
        la = 0;
        ra = 0;
        sv = 0;
        ok = 0;
        found = 0;
        case (op)
            OP_TICK: begin
                o_ticks++;
                for (int i = 0; i < NV; i++) begin
                    if (!act[i]) continue;
                    la = clampacc(la + contrib(i, 0));
                    ra = clampacc(ra + contrib(i, 1));
                    np = longint'(pos[i]) + longint'(stp[i]);
                    pos[i] = np[27:0];
                    if (np + 65536 >= (longint'(len[i]) << 16)) begin
                        if (loops[i]) pos[i] = 0;
                        else act[i] = 0;
                    end
                end
            end
            OP_WRITE: mem[addr] = {d[46:31], d[30:15]};
            OP_START: begin
                for (int i = 0; i < NV; i++)
                    if (act[i] && base[i] == addr) found = 1;
                if (!found || !d[101]) begin
                    for (int i = 0; i < NV; i++) begin
                        if (!act[i]) begin
                            act[i] = 1;
                            base[i] = addr;
                            len[i] = d[59:47];
                            loops[i] = d[60];
                            stp[i] = d[84:61];
                            gain[i] = d[100:85];
                            pos[i] = 0;
                            vol[i] = UNITY_VOLUME;
                            sv = i[3:0];
                            ok = 1;
                            o_starts++;
                            break;
                        end
                    end
                end
            end
            OP_STOP: begin
                for (int i = 0; i < NV; i++) begin
                    if (act[i] && base[i] == addr) begin
                        act[i] = 0;
                        pos[i] = 0;
                        break;
                    end
                end
            end
            OP_VOLUME: vol[vs] = d[121:106];
            default: ;
        endcase
        lo = 16'(flr(la + 32768, 16));
        ro = 16'(flr(ra + 32768, 16));
        mix_words.push_back({3'b0, vol[vs], ok, sv, ro, lo});
    endtask

    always @(posedge i_clk) begin
        logic [55:0] e;
        if (!i_rst_n) begin
            for (int i = 0; i < NV; i++) begin
                act[i] <= 0; base[i] <= 0; len[i] <= 0; loops[i] <= 0;
                stp[i] <= 0; pos[i] <= 0; vol[i] <= 0; gain[i] <= 0;
            end
        end else begin
            if (s_axis_tvalid && s_axis_tready) predict_mix(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                if (mix_words.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected word, expected none, actual %h",
                             $time, m_axis_tdata);
                end else begin
                    e = mix_words.pop_front();
                    if (e[15:0] !== m_axis_tdata[15:0] || e[31:16] !== m_axis_tdata[31:16]
                        || e[35:32] !== m_axis_tdata[35:32] || e[36] !== m_axis_tdata[36]
                        || e[52:37] !== m_axis_tdata[52:37]) begin
                        o_errors++;
                        $display("%0t: mismatch, expected L %0d R %0d v %0d ok %0b vol %0d,",
                                 $time, $signed(e[15:0]), $signed(e[31:16]), e[35:32],
                                 e[36], e[52:37]);
                        $display("    actual L %0d R %0d v %0d ok %0b vol %0d",
                                 $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[31:16]),
                                 m_axis_tdata[35:32], m_axis_tdata[36],
                                 m_axis_tdata[52:37]);
                    end
                end
            end
        end
    end

    assign o_pending = mix_words.size();

    initial begin
        o_errors = 0;
        o_ticks = 0;
        o_starts = 0;
    end

endmodule

// ===== tb/tb_sample_voice_mixer.sv =====
// Testbench top for the sample voice mixer: clock, reset, command stimulus
// with random idling and the verdict. Depends on svm_pkg and svm_checker.
module tb_sample_voice_mixer;
    import svm_pkg::*;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [55:0]  m_axis_tdata;
    int           errors, pending, ticks, starts;
    logic         quiet = 0;
    logic [11:0]  bases [4];
    logic         written [4096];

    sample_voice_mixer dut (.*);

    svm_checker chk (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .o_errors(errors), .o_pending(pending), .o_ticks(ticks), .o_starts(starts)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (quiet || $urandom_range(0, 3) != 0) m_axis_tready <= 1;
        else begin
            m_axis_tready <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            m_axis_tready <= 1;
        end
    end

    function automatic logic [127:0] pack_cmd(t_op op, logic [11:0] a, logic [15:0] l,
        logic [15:0] r, logic [12:0] n, logic lp, logic [23:0] st, logic [15:0] g,
        logic u, logic [3:0] v, logic [15:0] vl);
        return {6'b0, vl, v, u, g, st, lp, n, r, l, a, op};
    endfunction

    function automatic logic [127:0] rand_cmd(t_op op);
        logic [127:0] d;
        d = {$urandom, $urandom, $urandom, $urandom};
        d[2:0] = op;
        d[127:122] = '0;
        return d;
    endfunction

    task automatic send_cmd(input logic [127:0] d);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic write_word(input logic [11:0] a, input logic [15:0] l, r);
        written[a] = 1'b1;
        send_cmd(pack_cmd(OP_WRITE, a, l, r, 0, 0, 0, 0, 0, 4'($urandom),
                          16'($urandom)));
    endtask

    // A start only reads frames that are written, so fill the span it covers.
    // Long sounds are stopped before they get past their first frames.
    task automatic start_sound(input logic [11:0] b, input logic [12:0] n,
        input logic lp, input logic [23:0] st, input logic [15:0] g, input logic u);
        for (int k = 0; k <= ((n < 2) ? 1 : ((n > 31) ? 31 : n)); k++)
            if (!written[12'(b + k)])
                write_word(12'(b + k), 16'($urandom), 16'($urandom));
        send_cmd(pack_cmd(OP_START, b, 16'($urandom), 16'($urandom), n, lp, st, g, u,
                          4'($urandom), 16'($urandom)));
    endtask

    task automatic tick();
        send_cmd(rand_cmd(OP_TICK));
    endtask

    initial begin
        int r;
        logic [127:0] c;
        for (int i = 0; i < 4096; i++) written[i] = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // Directed: extreme samples, unity, full-scale gain and step, wrap at
        // memory end, zero and one lengths, refused unique start, stops.
        write_word(12'd4095, 16'h7fff, 16'h8000);
        write_word(12'd0, 16'h8000, 16'h7fff);
        start_sound(12'd4095, 13'd0, 0, 24'd0, 16'hffff, 0);
        start_sound(12'd4095, 13'd1, 1, 24'hffffff, 16'h8000, 1);
        start_sound(12'd4095, 13'd1, 1, 24'hffffff, 16'hffff, 0);
        send_cmd(pack_cmd(OP_VOLUME, 0, 0, 0, 0, 0, 0, 0, 0, 4'd1, 16'hffff));
        tick();
        tick();
        start_sound(12'd100, 13'd4096, 1, 24'h008000, 16'h4000, 0);
        send_cmd(pack_cmd(OP_VOLUME, 0, 0, 0, 0, 0, 0, 0, 0, 4'd15, 16'd0));
        tick();
        send_cmd(pack_cmd(OP_STOP, 12'd99, 0, 0, 0, 0, 0, 0, 0, 4'd0, 0));
        send_cmd(pack_cmd(OP_STOP, 12'd100, 0, 0, 0, 0, 0, 0, 0, 4'd0, 0));
        send_cmd(pack_cmd(t_op'(3'd7), 0, 0, 0, 0, 0, 0, 0, 0, 4'd2, 0));
        for (int i = 0; i < 17; i++) start_sound(12'(200 + i), 13'd3, 1, 24'h00c000,
                                                   16'h8000, 0);
        tick();
        for (int i = 0; i < 17; i++)
            send_cmd(pack_cmd(OP_STOP, 12'(200 + i), 0, 0, 0, 0, 0, 0, 0, 0, 0));
        for (int i = 0; i < 4; i++) bases[i] = 12'(300 + 40 * i);
        bases[3] = 12'd4080;
        for (int n = 0; n < 1150; n++) begin
            if (n > 1000) quiet = 1;
            r = $urandom_range(0, 9);
            case (r)
                0, 1: start_sound(bases[2'($urandom_range(0, 3))],
                                  13'($urandom_range(0, 30)), 1'($urandom),
                                  ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                  : 24'($urandom_range(0, 24'h30000)),
                                  16'($urandom), 1'($urandom));
                2: begin
                    c = rand_cmd(OP_STOP);
                    c[14:3] = bases[2'($urandom_range(0, 3))];
                    send_cmd(c);
                end
                3: send_cmd(rand_cmd(OP_VOLUME));
                4: write_word(12'($urandom), 16'($urandom), 16'($urandom));
                5: send_cmd(rand_cmd(t_op'(3'($urandom_range(5, 7)))));
                default: tick();
            endcase
        end
        s_axis_tvalid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        $display("Covered %0d ticks and %0d successful voice starts.", ticks, starts);
        if (errors == 0) $display("sample_voice_mixer verification clean");
        else $display("sample_voice_mixer verification failed");
        $finish;
    end

    initial begin
        #20000000;
        $display("sample_voice_mixer verification failed");
        $finish;
    end

endmodule
